// File: rtl/gmc_pkg.sv
// Package for the gate motor controller: gate state codes, register indexes,
// stream item types and configuration bundle. It depends on nothing else.
package gmc_pkg;

    typedef enum logic [2:0] {
        ST_INIT      = 3'd0,
        ST_OPENING   = 3'd1,
        ST_CLOSING   = 3'd2,
        ST_CLOSED    = 3'd3,
        ST_OPENED    = 3'd4,
        ST_EMERGENCY = 3'd5,
        ST_ERROR     = 3'd6,
        ST_WAIT      = 3'd7
    } t_state;

    localparam int RUN_W   = 12;
    localparam int DELAY_W = 8;
    localparam int PHASE_W = 2;
    localparam int ADDR_W  = 4;

    localparam logic [RUN_W-1:0]   RUN_MAX            = '1;
    localparam logic [RUN_W-1:0]   MOVE_TIMEOUT_RST   = 12'd3600;
    localparam logic [DELAY_W-1:0] EMERGENCY_HOLD_RST = 8'd30;
    localparam logic [DELAY_W-1:0] BLINK_HALF_RST     = 8'd10;

    // Blink phases of the error state: lamp on, off, on.
    localparam logic [PHASE_W-1:0] PHASE_FIRST_ON = 2'd0;
    localparam logic [PHASE_W-1:0] PHASE_OFF      = 2'd1;
    localparam logic [PHASE_W-1:0] PHASE_LAST_ON  = 2'd2;

    // Register indexes, taken from paddr[3:2].
    localparam logic [1:0] REG_MOVE_TIMEOUT   = 2'd0;
    localparam logic [1:0] REG_EMERGENCY_HOLD = 2'd1;
    localparam logic [1:0] REG_BLINK_HALF     = 2'd2;

    typedef struct packed {
        logic limit_open;
        logic limit_closed;
        logic cmd_open;
        logic cmd_close;
        logic photocell_blocked;
    } t_in_item;

    typedef struct packed {
        logic   motor_open;
        logic   motor_close;
        logic   led_alarm;
        logic   led_moving;
        t_state gate_state;
    } t_out_item;

    typedef struct packed {
        logic [RUN_W-1:0]   move_timeout_ticks;
        logic [DELAY_W-1:0] emergency_hold_ticks;
        logic [DELAY_W-1:0] blink_half_ticks;
    } t_cfg;

endpackage

// File: rtl/gate_motor_controller.sv
// Top level of the gate motor controller: stream ports, APB register file,
// input and result registers. Depends on gmc_pkg and gmc_core.
//
// Each input transaction is one tick of sampled limit switches, commands and
// photocell; each produces exactly one output transaction with the motor and
// lamp drives and the gate state whose handler ran on that tick. The block
// takes one transaction per clock cycle when the output side keeps up. An
// accepted item sits in the input register while the state machine step is
// worked out; the result is written to the result register once that
// register is free, and is offered from there.
// All timing (run timeout, emergency hold, blink phases) is counted in ticks,
// not clock cycles. Registers: 0x0 move timeout (12 bits), 0x4 emergency hold
// (8 bits), 0x8 blink half period (8 bits); write them only while idle.
module gate_motor_controller (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // APB configuration port
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [gmc_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready,
    // Input stream
    input  logic                       s_axis_tvalid,
    output logic                       s_axis_tready,
    // [0] limit_open, [1] limit_closed, [2] cmd_open, [3] cmd_close,
    // [4] photocell_blocked, [7:5] zero
    input  logic [7:0]                 s_axis_tdata,
    // Output stream
    output logic                       m_axis_tvalid,
    input  logic                       m_axis_tready,
    // [0] motor_open, [1] motor_close, [2] led_alarm, [3] led_moving,
    // [6:4] gate_state, [7] zero
    output logic [7:0]                 m_axis_tdata
);
    import gmc_pkg::*;

    t_cfg      r_cfg;
    logic      r_in_valid;
    t_in_item  r_in_item;
    logic      r_out_valid;
    t_out_item r_out_item;
    t_out_item core_result;
    logic      advance;
    logic      in_fire;
    logic      cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.move_timeout_ticks   <= MOVE_TIMEOUT_RST;
            r_cfg.emergency_hold_ticks <= EMERGENCY_HOLD_RST;
            r_cfg.blink_half_ticks     <= BLINK_HALF_RST;
        end else if (cfg_write) begin
            case (paddr[3:2])
                REG_MOVE_TIMEOUT:   r_cfg.move_timeout_ticks   <= pwdata[RUN_W-1:0];
                REG_EMERGENCY_HOLD: r_cfg.emergency_hold_ticks <= pwdata[DELAY_W-1:0];
                REG_BLINK_HALF:     r_cfg.blink_half_ticks     <= pwdata[DELAY_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_MOVE_TIMEOUT:   prdata = {{(32-RUN_W){1'b0}}, r_cfg.move_timeout_ticks};
            REG_EMERGENCY_HOLD: prdata = {{(32-DELAY_W){1'b0}}, r_cfg.emergency_hold_ticks};
            REG_BLINK_HALF:     prdata = {{(32-DELAY_W){1'b0}}, r_cfg.blink_half_ticks};
            default:            prdata = '0;
        endcase
    end

    // The held item steps the state machine when the result register is free.
    assign advance       = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || advance;
    assign in_fire       = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_fire) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_in_item.limit_open        <= s_axis_tdata[0];
            r_in_item.limit_closed      <= s_axis_tdata[1];
            r_in_item.cmd_open          <= s_axis_tdata[2];
            r_in_item.cmd_close         <= s_axis_tdata[3];
            r_in_item.photocell_blocked <= s_axis_tdata[4];
        end
        if (advance) begin
            r_out_item <= core_result;
        end
    end

    gmc_core u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (advance),
        .i_item    (r_in_item),
        .i_cfg     (r_cfg),
        .o_result  (core_result)
    );

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {1'b0, r_out_item.gate_state, r_out_item.led_moving,
                            r_out_item.led_alarm, r_out_item.motor_close,
                            r_out_item.motor_open};

endmodule

// File: rtl/gmc_core.sv
// Gate state machine with its run counter, hold/blink timer and blink phase.
// Depends on gmc_pkg. State advances once for every item the top level issues.
module gmc_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_advance,
    input  gmc_pkg::t_in_item i_item,
    input  gmc_pkg::t_cfg     i_cfg,
    output gmc_pkg::t_out_item o_result
);
    import gmc_pkg::*;

    t_state               r_state;
    t_state               n_state;
    t_state               r_return;
    t_state               n_return;
    logic [RUN_W-1:0]     r_run;
    logic [RUN_W-1:0]     n_run;
    logic [DELAY_W-1:0]   r_delay;
    logic [DELAY_W-1:0]   n_delay;
    logic [PHASE_W-1:0]   r_phase;
    logic [PHASE_W-1:0]   n_phase;

    logic [RUN_W-1:0]     run_base;
    logic                 timeout;
    logic [DELAY_W:0]     delay_inc;
    logic                 lo, lc, ca, cc, fc;

    assign lo = i_item.limit_open;
    assign lc = i_item.limit_closed;
    assign ca = i_item.cmd_open;
    assign cc = i_item.cmd_close;
    assign fc = i_item.photocell_blocked;

    assign delay_inc = {1'b0, r_delay} + {{DELAY_W{1'b0}}, 1'b1};

    always_comb begin
        run_base = (ca || cc) ? '0 : r_run;
        n_run    = '0;
        timeout  = 1'b0;
        if (r_state == ST_OPENING || r_state == ST_CLOSING) begin
            // Counter saturates; a timeout register of zero trips like one.
            n_run   = (run_base == RUN_MAX) ? run_base : run_base + 1'b1;
            timeout = n_run >= i_cfg.move_timeout_ticks;
        end
    end

    always_comb begin
        n_state  = r_state;
        n_return = r_return;
        n_delay  = '0;
        n_phase  = '0;
        o_result = '{motor_open: 1'b0, motor_close: 1'b0, led_alarm: 1'b0,
                     led_moving: 1'b0, gate_state: r_state};
        case (r_state)
            ST_INIT: begin
                n_state = ST_WAIT;
            end
            ST_WAIT: begin
                if (!lo && !fc && !lc) begin
                    n_state = ST_CLOSING;
                end else if (ca && !fc && !lo) begin
                    n_state = ST_OPENING;
                end else if (cc && !fc) begin
                    n_state = ST_CLOSING;
                end else if (ca && !fc) begin
                    n_state = ST_OPENING;
                end else if (fc) begin
                    n_state  = ST_EMERGENCY;
                    n_return = ST_WAIT;
                end else if (lo && lc) begin
                    n_state = ST_ERROR;
                end
            end
            ST_OPENING: begin
                o_result.motor_open = 1'b1;
                o_result.led_moving = 1'b1;
                if (lo && lc) begin
                    n_state = ST_ERROR;
                end else if (lo) begin
                    n_state = ST_OPENED;
                end else if (fc) begin
                    n_state  = ST_EMERGENCY;
                    n_return = ST_OPENING;
                end else if (cc) begin
                    n_state = ST_CLOSING;
                end else if (timeout) begin
                    n_state = ST_ERROR;
                end
            end
            ST_CLOSING: begin
                o_result.motor_close = 1'b1;
                o_result.led_moving  = 1'b1;
                if (lo && lc) begin
                    n_state = ST_ERROR;
                end else if (lc) begin
                    n_state = ST_CLOSED;
                end else if (fc) begin
                    n_state  = ST_EMERGENCY;
                    n_return = ST_CLOSING;
                end else if (ca) begin
                    n_state = ST_OPENING;
                end else if (timeout) begin
                    n_state = ST_ERROR;
                end
            end
            ST_CLOSED, ST_OPENED: begin
                n_state = ST_WAIT;
            end
            ST_EMERGENCY: begin
                o_result.led_alarm = 1'b1;
                // On the last tick of a hold, a clear photocell ends the emergency;
                // a blocked one starts a new hold.
                if (delay_inc >= {1'b0, i_cfg.emergency_hold_ticks}) begin
                    if (!fc) begin
                        n_state = r_return;
                    end
                end else begin
                    n_delay = delay_inc[DELAY_W-1:0];
                end
            end
            default: begin
                // Error: blink on, off, on; phase code 3 acts as the last phase.
                o_result.led_alarm = (r_phase != PHASE_OFF);
                if (delay_inc >= {1'b0, i_cfg.blink_half_ticks}) begin
                    if (r_phase >= PHASE_LAST_ON) begin
                        n_state = ST_WAIT;
                    end else begin
                        n_phase = r_phase + 1'b1;
                    end
                end else begin
                    n_delay = delay_inc[DELAY_W-1:0];
                    n_phase = r_phase;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_INIT;
            r_return <= ST_INIT;
            r_run    <= '0;
            r_delay  <= '0;
            r_phase  <= PHASE_FIRST_ON;
        end else if (i_advance) begin
            r_state  <= n_state;
            r_return <= n_return;
            r_run    <= n_run;
            r_delay  <= n_delay;
            r_phase  <= n_phase;
        end
    end

endmodule

// File: rtl/gmc_checker.sv
// Port-level checker for the gate motor controller, bound to the top level.
// Depends on gmc_pkg for the gate state codes.
module gmc_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       m_axis_tvalid,
    input logic       m_axis_tready,
    input logic [7:0] m_axis_tdata
);
    import gmc_pkg::*;

    // The motor is never driven both ways in one result.
    a_motor_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !(m_axis_tdata[0] && m_axis_tdata[1]))
        else $error("motor driven in both directions");

    // The motion lamp follows the motor drives.
    a_moving_lamp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[3] == (m_axis_tdata[0] || m_axis_tdata[1])))
        else $error("motion lamp disagrees with motor drives");

    // Opening drive only in the opening state, closing drive only in closing.
    a_drive_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tdata[0] || m_axis_tdata[1]) |->
            (m_axis_tdata[0] ? (m_axis_tdata[6:4] == ST_OPENING)
                             : (m_axis_tdata[6:4] == ST_CLOSING)))
        else $error("motor drive outside its motion state");

    // A stalled result transaction holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output transaction changed while stalled");

endmodule

bind gate_motor_controller gmc_checker u_gmc_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
